>>> src/mvn_pkg.sv
// Shared types and constants for the mesh vertex normal accumulator.
// Used by mvn_ctrl, mvn_dp and the top level; depends on nothing.
package mvn_pkg;

    localparam int VERTEX_DEPTH_DEF = 2048;

    // input item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TRI  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // result kinds
    localparam logic RES_TRI  = 1'b0;
    localparam logic RES_READ = 1'b1;

    localparam int STEP_W     = 5;
    localparam int SQRT_STEPS = 31;   // root bits 30 down to 0
    localparam int DIV_STEPS  = 15;   // quotient bits
    localparam int SQRT_TOP   = 60;   // first trial bit of the root

    localparam logic [15:0] ONE_Q14 = 16'd16384;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_CLEAR,
        DP_LOAD,
        DP_READ,
        DP_LATCH_POS,
        DP_DIFF,
        DP_CROSS_MUL,
        DP_CROSS_SUB,
        DP_READ_LATCH,
        DP_RD_ZERO,
        DP_PREP,
        DP_SQ_MUL,
        DP_SQ_ADD,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_DONE,
        DP_ZERO_N,
        DP_ACC_WR,
        DP_OUT_TRI,
        DP_OUT_READ
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_IDX,
        SEL_A,
        SEL_B,
        SEL_C
    } sel_t;

    typedef struct packed {
        dp_op_t     op;
        sel_t       sel;
        logic [1:0] lane;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       idx_ok;
        logic       tri_ok;
        logic       count_zero;
        logic       vec_zero;
    } status_t;

endpackage

>>> src/mvn_ctrl.sv
// Sequencer for the vertex normal accumulator: steps the datapath through
// load, triangle and readout work. Depends on mvn_pkg.
module mvn_ctrl #(
    parameter int VERTEX_DEPTH = mvn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output mvn_pkg::cmd_t                     cmd,
    output logic [$clog2(VERTEX_DEPTH)-1:0]   clr_addr,
    input  mvn_pkg::status_t                  status
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_FETCH,
        S_DIFF,
        S_CROSS,
        S_RFETCH,
        S_RCHK,
        S_PREP,
        S_ZCHK,
        S_SQ,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_DONE,
        S_ACC,
        S_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [mvn_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [1:0]                      lane_reg, lane_next;
    logic [AW-1:0]                   clr_reg, clr_next;
    logic                            is_read_reg, is_read_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    function automatic mvn_pkg::sel_t corner_sel(input logic [1:0] c);
        case (c)
            2'd0:    return mvn_pkg::SEL_A;
            2'd1:    return mvn_pkg::SEL_B;
            default: return mvn_pkg::SEL_C;
        endcase
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign clr_addr = clr_reg;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        lane_next     = lane_reg;
        clr_next      = clr_reg;
        is_read_next  = is_read_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        cmd.op        = mvn_pkg::DP_NOP;
        cmd.sel       = mvn_pkg::SEL_IDX;
        cmd.lane      = 2'd0;

        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = mvn_pkg::DP_CLEAR;
                if (clr_reg == AW'(VERTEX_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = mvn_pkg::DP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                step_next = '0;
                lane_next = 2'd0;
                unique case (status.kind)
                    mvn_pkg::KIND_LOAD: begin
                        state_next = status.idx_ok ? S_LOAD : S_IDLE;
                    end
                    mvn_pkg::KIND_TRI: begin
                        is_read_next = 1'b0;
                        state_next   = status.tri_ok ? S_FETCH : S_EMIT;
                    end
                    mvn_pkg::KIND_READ: begin
                        is_read_next = 1'b1;
                        if (status.idx_ok) begin
                            state_next = S_RFETCH;
                        end else begin
                            cmd.op     = mvn_pkg::DP_RD_ZERO;
                            state_next = S_EMIT;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOAD: begin
                cmd.op     = mvn_pkg::DP_LOAD;
                state_next = S_IDLE;
            end
            S_FETCH: begin
                cmd.op  = step_reg[0] ? mvn_pkg::DP_LATCH_POS : mvn_pkg::DP_READ;
                cmd.sel = corner_sel(step_reg[2:1]);
                if (step_reg == mvn_pkg::STEP_W'(5)) begin
                    state_next = S_DIFF;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIFF: begin
                cmd.op     = mvn_pkg::DP_DIFF;
                state_next = S_CROSS;
            end
            S_CROSS: begin
                cmd.op   = step_reg[0] ? mvn_pkg::DP_CROSS_SUB : mvn_pkg::DP_CROSS_MUL;
                cmd.lane = step_reg[2:1];
                if (step_reg == mvn_pkg::STEP_W'(5)) begin
                    state_next = S_PREP;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_RFETCH: begin
                if (step_reg[0]) begin
                    cmd.op     = mvn_pkg::DP_READ_LATCH;
                    state_next = S_RCHK;
                    step_next  = '0;
                end else begin
                    cmd.op    = mvn_pkg::DP_READ;
                    step_next = step_reg + 1'b1;
                end
            end
            S_RCHK: begin
                if (status.count_zero) begin
                    cmd.op     = mvn_pkg::DP_ZERO_N;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.op     = mvn_pkg::DP_PREP;
                state_next = S_ZCHK;
            end
            S_ZCHK: begin
                step_next = '0;
                if (status.vec_zero) begin
                    // degenerate: zero normal; a triangle still adds it and counts the corners
                    cmd.op     = mvn_pkg::DP_ZERO_N;
                    state_next = is_read_reg ? S_EMIT : S_ACC;
                end else begin
                    state_next = S_SQ;
                end
            end
            S_SQ: begin
                cmd.op   = step_reg[0] ? mvn_pkg::DP_SQ_ADD : mvn_pkg::DP_SQ_MUL;
                cmd.lane = step_reg[2:1];
                if (step_reg == mvn_pkg::STEP_W'(5)) begin
                    state_next = S_SQRT_INIT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_SQRT_INIT: begin
                cmd.op     = mvn_pkg::DP_SQRT_INIT;
                state_next = S_SQRT;
                step_next  = '0;
            end
            S_SQRT: begin
                cmd.op = mvn_pkg::DP_SQRT_STEP;
                if (step_reg == mvn_pkg::STEP_W'(mvn_pkg::SQRT_STEPS - 1)) begin
                    state_next = S_DIV_INIT;
                    lane_next  = 2'd0;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIV_INIT: begin
                cmd.op     = mvn_pkg::DP_DIV_INIT;
                cmd.lane   = lane_reg;
                state_next = S_DIV;
                step_next  = '0;
            end
            S_DIV: begin
                cmd.op = mvn_pkg::DP_DIV_STEP;
                if (step_reg == mvn_pkg::STEP_W'(mvn_pkg::DIV_STEPS - 1)) begin
                    state_next = S_DIV_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIV_DONE: begin
                cmd.op    = mvn_pkg::DP_DIV_DONE;
                cmd.lane  = lane_reg;
                step_next = '0;
                if (lane_reg == 2'd2) begin
                    state_next = is_read_reg ? S_EMIT : S_ACC;
                end else begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = S_DIV_INIT;
                end
            end
            S_ACC: begin
                // read-modify-write each corner in turn: a, b, c
                cmd.op  = step_reg[0] ? mvn_pkg::DP_ACC_WR : mvn_pkg::DP_READ;
                cmd.sel = corner_sel(step_reg[2:1]);
                if (step_reg == mvn_pkg::STEP_W'(5)) begin
                    state_next = S_EMIT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_EMIT: begin
                // hold until the output word is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = is_read_reg ? mvn_pkg::DP_OUT_READ : mvn_pkg::DP_OUT_TRI;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            step_reg     <= '0;
            lane_reg     <= 2'd0;
            clr_reg      <= '0;
            is_read_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            lane_reg     <= lane_next;
            clr_reg      <= clr_next;
            is_read_reg  <= is_read_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> src/mvn_dp.sv
// Datapath of the vertex normal accumulator: vertex and sum memories,
// cross product, square-root and divider units, result registers. Depends on mvn_pkg.
module mvn_dp #(
    parameter int VERTEX_DEPTH = mvn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                              aclk,
    input  mvn_pkg::cmd_t                     cmd,
    input  logic [$clog2(VERTEX_DEPTH)-1:0]   clr_addr,
    output mvn_pkg::status_t                  status,
    input  logic [1:0]                        in_kind,
    input  logic [10:0]                       in_vertex_index,
    input  logic signed [15:0]                in_pos_x,
    input  logic signed [15:0]                in_pos_y,
    input  logic signed [15:0]                in_pos_z,
    input  logic [10:0]                       in_corner_first,
    input  logic [10:0]                       in_corner_second,
    input  logic [10:0]                       in_corner_third,
    output logic                              out_result_kind,
    output logic [10:0]                       out_tri_first,
    output logic [10:0]                       out_tri_second,
    output logic [10:0]                       out_tri_third,
    output logic signed [15:0]                out_normal_x,
    output logic signed [15:0]                out_normal_y,
    output logic signed [15:0]                out_normal_z,
    output logic signed [15:0]                out_stored_x,
    output logic signed [15:0]                out_stored_y,
    output logic signed [15:0]                out_stored_z,
    output logic [7:0]                        out_use_total
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    // memories: position {z, y, x}; sums {count, z, y, x}
    logic [47:0] pos_mem [VERTEX_DEPTH];
    logic [79:0] acc_mem [VERTEX_DEPTH];
    logic [47:0] pos_q;
    logic [79:0] acc_q;

    // captured item
    logic [1:0]         kind_reg;
    logic [10:0]        idx_reg, ca_reg, cb_reg, cc_reg;
    logic signed [15:0] px_reg, py_reg, pz_reg;

    logic signed [15:0] pv_reg [3][3];   // corner a, b, c by component
    logic signed [16:0] u_reg [3];
    logic signed [16:0] w_reg [3];
    logic signed [33:0] prod_a_reg, prod_b_reg;
    logic signed [34:0] vec_reg [3];
    logic [29:0]        m_reg [3];
    logic [2:0]         neg_reg;
    logic [59:0]        sq_reg;
    logic [61:0]        l2_reg;
    logic [61:0]        sv_reg, sr_reg, sbit_reg;
    logic [31:0]        dr_reg;
    logic [14:0]        dq_reg;
    logic signed [15:0] n_reg [3];
    logic [47:0]        rd_pos_reg;
    logic [7:0]         rd_cnt_reg;

    logic               res_kind_reg;
    logic [10:0]        res_tri_reg [3];
    logic signed [15:0] res_n_reg [3];
    logic [47:0]        res_pos_reg;
    logic [7:0]         res_cnt_reg;

    logic [10:0]   sel_idx;
    logic [AW-1:0] sel_addr, acc_waddr;
    logic          acc_we;
    logic [79:0]   acc_wdata;
    logic [15:0]   x_store;
    logic [1:0]    corner;
    logic [1:0]    k1, k2;
    logic [33:0]   mag [3];
    logic [33:0]   mag_or;
    logic [2:0]    shamt;
    logic [62:0]   sq_trial;
    logic          sq_take;
    logic [30:0]   len;
    logic [44:0]   dividend;
    logic [31:0]   rem2;
    logic          div_take;
    logic [14:0]   q_clamp;
    logic [7:0]    cnt_inc;

    function automatic logic [23:0] sat_add24(input logic signed [23:0] s,
                                              input logic signed [15:0] d);
        logic signed [24:0] t;
        t = 25'(s) + 25'(d);
        if (t[24] != t[23]) begin
            return t[24] ? 24'h800000 : 24'h7fffff;
        end
        return t[23:0];
    endfunction

    always_comb begin
        case (cmd.sel)
            mvn_pkg::SEL_A: sel_idx = ca_reg;
            mvn_pkg::SEL_B: sel_idx = cb_reg;
            mvn_pkg::SEL_C: sel_idx = cc_reg;
            default:        sel_idx = idx_reg;
        endcase
        case (cmd.sel)
            mvn_pkg::SEL_B: corner = 2'd1;
            mvn_pkg::SEL_C: corner = 2'd2;
            default:        corner = 2'd0;
        endcase
        case (cmd.lane)
            2'd0:    begin k1 = 2'd1; k2 = 2'd2; end
            2'd1:    begin k1 = 2'd2; k2 = 2'd0; end
            default: begin k1 = 2'd0; k2 = 2'd1; end
        endcase
    end

    assign sel_addr  = AW'(sel_idx);
    assign acc_waddr = (cmd.op == mvn_pkg::DP_CLEAR) ? clr_addr : sel_addr;
    assign acc_we    = (cmd.op == mvn_pkg::DP_CLEAR) || (cmd.op == mvn_pkg::DP_LOAD) ||
                       (cmd.op == mvn_pkg::DP_ACC_WR);

    // negate x; the most negative input clamps to the largest positive
    assign x_store = (px_reg == 16'sh8000) ? 16'h7fff : 16'(16'sd0 - px_reg);

    assign cnt_inc = (acc_q[79:72] == 8'hff) ? 8'hff : acc_q[79:72] + 8'd1;

    always_comb begin
        if (cmd.op == mvn_pkg::DP_ACC_WR) begin
            acc_wdata = {cnt_inc,
                         sat_add24(acc_q[71:48], n_reg[2]),
                         sat_add24(acc_q[47:24], n_reg[1]),
                         sat_add24(acc_q[23:0],  n_reg[0])};
        end else begin
            acc_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == mvn_pkg::DP_LOAD) begin
            pos_mem[sel_addr] <= {pz_reg, py_reg, x_store};
        end
        if (cmd.op == mvn_pkg::DP_READ) begin
            pos_q <= pos_mem[sel_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (cmd.op == mvn_pkg::DP_READ) begin
            acc_q <= acc_mem[sel_addr];
        end
    end

    // magnitudes and the shift that brings the largest below 2^30
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = vec_reg[i][34] ? 34'(35'sd0 - vec_reg[i]) : 34'(vec_reg[i]);
        end
        mag_or = mag[0] | mag[1] | mag[2];
        if (mag_or[33])      shamt = 3'd4;
        else if (mag_or[32]) shamt = 3'd3;
        else if (mag_or[31]) shamt = 3'd2;
        else if (mag_or[30]) shamt = 3'd1;
        else                 shamt = 3'd0;
    end

    assign sq_trial = {1'b0, sr_reg} + {1'b0, sbit_reg};
    assign sq_take  = {1'b0, sv_reg} >= sq_trial;
    assign len      = sr_reg[30:0];
    assign dividend = {1'b0, m_reg[cmd.lane], 14'd0} + 45'(len[30:1]);
    assign rem2     = {dr_reg[30:0], dq_reg[14]};
    assign div_take = rem2 >= {1'b0, len};
    assign q_clamp  = (dq_reg > mvn_pkg::ONE_Q14[14:0]) ? mvn_pkg::ONE_Q14[14:0] : dq_reg;

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            mvn_pkg::DP_CAPTURE: begin
                kind_reg <= in_kind;
                idx_reg  <= in_vertex_index;
                px_reg   <= in_pos_x;
                py_reg   <= in_pos_y;
                pz_reg   <= in_pos_z;
                ca_reg   <= in_corner_third;
                cb_reg   <= in_corner_second;
                cc_reg   <= in_corner_first;
            end
            mvn_pkg::DP_LATCH_POS: begin
                pv_reg[corner][0] <= pos_q[15:0];
                pv_reg[corner][1] <= pos_q[31:16];
                pv_reg[corner][2] <= pos_q[47:32];
            end
            mvn_pkg::DP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    u_reg[i] <= 17'(pv_reg[0][i]) - 17'(pv_reg[1][i]);
                    w_reg[i] <= 17'(pv_reg[2][i]) - 17'(pv_reg[1][i]);
                end
            end
            mvn_pkg::DP_CROSS_MUL: begin
                prod_a_reg <= u_reg[k1] * w_reg[k2];
                prod_b_reg <= u_reg[k2] * w_reg[k1];
            end
            mvn_pkg::DP_CROSS_SUB: begin
                vec_reg[cmd.lane] <= 35'(prod_a_reg) - 35'(prod_b_reg);
            end
            mvn_pkg::DP_READ_LATCH: begin
                vec_reg[0] <= 35'($signed(acc_q[23:0]));
                vec_reg[1] <= 35'($signed(acc_q[47:24]));
                vec_reg[2] <= 35'($signed(acc_q[71:48]));
                rd_pos_reg <= pos_q;
                rd_cnt_reg <= acc_q[79:72];
            end
            mvn_pkg::DP_RD_ZERO: begin
                rd_pos_reg <= '0;
                rd_cnt_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    n_reg[i] <= '0;
                end
            end
            mvn_pkg::DP_PREP: begin
                for (int i = 0; i < 3; i++) begin
                    m_reg[i]   <= 30'(mag[i] >> shamt);
                    neg_reg[i] <= vec_reg[i][34];
                end
                l2_reg <= '0;
            end
            mvn_pkg::DP_SQ_MUL: begin
                sq_reg <= m_reg[cmd.lane] * m_reg[cmd.lane];
            end
            mvn_pkg::DP_SQ_ADD: begin
                l2_reg <= l2_reg + 62'(sq_reg);
            end
            mvn_pkg::DP_SQRT_INIT: begin
                sv_reg   <= l2_reg;
                sr_reg   <= '0;
                sbit_reg <= 62'(1) << mvn_pkg::SQRT_TOP;
            end
            mvn_pkg::DP_SQRT_STEP: begin
                if (sq_take) begin
                    sv_reg <= sv_reg - sq_trial[61:0];
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            mvn_pkg::DP_DIV_INIT: begin
                dr_reg <= 32'(dividend[44:15]);
                dq_reg <= dividend[14:0];
            end
            mvn_pkg::DP_DIV_STEP: begin
                dr_reg <= div_take ? rem2 - {1'b0, len} : rem2;
                dq_reg <= {dq_reg[13:0], div_take};
            end
            mvn_pkg::DP_DIV_DONE: begin
                n_reg[cmd.lane] <= neg_reg[cmd.lane] ? 16'(16'd0 - 16'(q_clamp))
                                                     : 16'(q_clamp);
            end
            mvn_pkg::DP_ZERO_N: begin
                for (int i = 0; i < 3; i++) begin
                    n_reg[i] <= '0;
                end
            end
            mvn_pkg::DP_OUT_TRI: begin
                res_kind_reg   <= mvn_pkg::RES_TRI;
                res_tri_reg[0] <= ca_reg;
                res_tri_reg[1] <= cb_reg;
                res_tri_reg[2] <= cc_reg;
                for (int i = 0; i < 3; i++) begin
                    res_n_reg[i] <= '0;
                end
                res_pos_reg <= '0;
                res_cnt_reg <= '0;
            end
            mvn_pkg::DP_OUT_READ: begin
                res_kind_reg <= mvn_pkg::RES_READ;
                for (int i = 0; i < 3; i++) begin
                    res_tri_reg[i] <= '0;
                    res_n_reg[i]   <= n_reg[i];
                end
                res_pos_reg <= rd_pos_reg;
                res_cnt_reg <= rd_cnt_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.kind       = kind_reg;
    assign status.idx_ok     = 32'(idx_reg) < VERTEX_DEPTH;
    assign status.tri_ok     = (32'(ca_reg) < VERTEX_DEPTH) && (32'(cb_reg) < VERTEX_DEPTH) &&
                               (32'(cc_reg) < VERTEX_DEPTH);
    assign status.count_zero = (rd_cnt_reg == 8'd0);
    assign status.vec_zero   = (m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0);

    assign out_result_kind = res_kind_reg;
    assign out_tri_first   = res_tri_reg[0];
    assign out_tri_second  = res_tri_reg[1];
    assign out_tri_third   = res_tri_reg[2];
    assign out_normal_x    = res_n_reg[0];
    assign out_normal_y    = res_n_reg[1];
    assign out_normal_z    = res_n_reg[2];
    assign out_stored_x    = res_pos_reg[15:0];
    assign out_stored_y    = res_pos_reg[31:16];
    assign out_stored_z    = res_pos_reg[47:32];
    assign out_use_total   = res_cnt_reg;

endmodule

>>> src/mesh_vertex_normal_accumulator_core.sv
// Top level of the mesh vertex normal accumulator: stream ports, controller
// and datapath. Depends on mvn_pkg, mvn_ctrl and mvn_dp.
//
//  channel | ports                   | moves
//  --------+-------------------------+------------------------------------------
//  input   | s_tvalid/s_tready/s_*   | load, triangle or read word (kind in tuser)
//  output  | m_tvalid/m_tready/m_*   | reordered triangle or normal readout word
//
// A triangle whose cross product is zero, a read whose sum is zero and a read of an
// unused vertex skip the normalisation; elsewhere the 31-step square root and three
// divisions dominate. Out-of-range triangles and reads go straight to the output.
// Reset: a clearing pass writes zero sums and counts to every slot, one per
// cycle (VERTEX_DEPTH slots, 2048 by default) with s_tready low.
// Stalls: a result waits in the output register while the next word is taken.
module mesh_vertex_normal_accumulator_core #(
    parameter int VERTEX_DEPTH = mvn_pkg::VERTEX_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_first, corner_second, corner_third
    input  logic [95:0]   s_tdata,
    // kind
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // tri_out_first, tri_out_second, tri_out_third, normal_x, normal_y,
    // normal_z, stored_x, stored_y, stored_z, use_total
    output logic [143:0]  m_tdata,
    // result_kind
    output logic [0:0]    m_tuser
);

    mvn_pkg::cmd_t                     cmd;
    mvn_pkg::status_t                  status;
    logic [$clog2(VERTEX_DEPTH)-1:0]   clr_addr;

    logic               res_kind;
    logic [10:0]        tri_first, tri_second, tri_third;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic signed [15:0] stored_x, stored_y, stored_z;
    logic [7:0]         use_total;

    mvn_ctrl #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .clr_addr (clr_addr),
        .status   (status)
    );

    mvn_dp #(
        .VERTEX_DEPTH (VERTEX_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .cmd              (cmd),
        .clr_addr         (clr_addr),
        .status           (status),
        .in_kind          (s_tuser),
        .in_vertex_index  (s_tdata[10:0]),
        .in_pos_x         (s_tdata[26:11]),
        .in_pos_y         (s_tdata[42:27]),
        .in_pos_z         (s_tdata[58:43]),
        .in_corner_first  (s_tdata[69:59]),
        .in_corner_second (s_tdata[80:70]),
        .in_corner_third  (s_tdata[91:81]),
        .out_result_kind  (res_kind),
        .out_tri_first    (tri_first),
        .out_tri_second   (tri_second),
        .out_tri_third    (tri_third),
        .out_normal_x     (normal_x),
        .out_normal_y     (normal_y),
        .out_normal_z     (normal_z),
        .out_stored_x     (stored_x),
        .out_stored_y     (stored_y),
        .out_stored_z     (stored_z),
        .out_use_total    (use_total)
    );

    assign m_tuser = res_kind;
    assign m_tdata = {7'd0, use_total, stored_z, stored_y, stored_x,
                      normal_z, normal_y, normal_x, tri_third, tri_second, tri_first};

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for mesh_vertex_normal_accumulator_core: drives load, triangle
// and read words and checks each result against a built-in vertex normal predictor.
// Depends on mvn_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = mvn_pkg::VERTEX_DEPTH_DEF;
    // kind code the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic        rkind;
        logic [10:0] tri_a, tri_b, tri_c;
        logic [15:0] nx, ny, nz;
        logic [15:0] sx, sy, sz;
        logic [7:0]  uses;
    } normal_word_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [95:0]   s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [143:0]  m_tdata;
    logic [0:0]    m_tuser;

    // vertex state mirrored by the predictor
    logic signed [15:0] vpos [DEPTH][3];
    int                 nsum [DEPTH][3];
    int unsigned        ucount [DEPTH];
    bit                 loaded [DEPTH];
    int                 loaded_q[$];

    normal_word_t pending_q[$];
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    mesh_vertex_normal_accumulator_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void unit_normal(input longint vx, vy, vz, output int nx, ny, nz);
        longint v [3];
        longint unsigned m [3];
        longint unsigned mx, l2, len, q;
        int n [3];
        v[0] = vx; v[1] = vy; v[2] = vz;
        mx = 0;
        l2 = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        for (int i = 0; i < 3; i++) l2 += m[i] * m[i];
        if (l2 == 0) begin
            nx = 0; ny = 0; nz = 0;
            return;
        end
        len = int_sqrt(l2);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            if (q > 16384) q = 16384;
            n[i] = v[i] < 0 ? -int'(q) : int'(q);
        end
        nx = n[0]; ny = n[1]; nz = n[2];
    endfunction

    function automatic void add_to_vertex(int k, int nx, int ny, int nz);
        int d [3];
        longint t;
        d[0] = nx; d[1] = ny; d[2] = nz;
        for (int i = 0; i < 3; i++) begin
            t = longint'(nsum[k][i]) + d[i];
            if (t > 8388607) t = 8388607;
            if (t < -8388608) t = -8388608;
            nsum[k][i] = int'(t);
        end
        if (ucount[k] < 255) ucount[k]++;
    endfunction

    // advance the vertex state for one accepted word and queue its result
    function automatic void predict_word(logic [1:0] kind, logic [10:0] idx,
                                         logic signed [15:0] px, py, pz,
                                         logic [10:0] cf, cs, ct);
        normal_word_t r;
        longint u [3], w [3];
        int nx, ny, nz, x;
        r = '{default: '0};
        if (kind == mvn_pkg::KIND_LOAD) begin
            x = -int'(px);
            if (x > 32767) x = 32767;
            vpos[idx][0] = 16'(x);
            vpos[idx][1] = py;
            vpos[idx][2] = pz;
            nsum[idx] = '{0, 0, 0};
            ucount[idx] = 0;
            if (!loaded[idx]) loaded_q.push_back(int'(idx));
            loaded[idx] = 1;
        end else if (kind == mvn_pkg::KIND_TRI) begin
            r.rkind = mvn_pkg::RES_TRI;
            r.tri_a = ct; r.tri_b = cs; r.tri_c = cf;
            for (int i = 0; i < 3; i++) begin
                u[i] = longint'(vpos[ct][i]) - vpos[cs][i];
                w[i] = longint'(vpos[cf][i]) - vpos[cs][i];
            end
            unit_normal(u[1] * w[2] - u[2] * w[1], u[2] * w[0] - u[0] * w[2],
                        u[0] * w[1] - u[1] * w[0], nx, ny, nz);
            add_to_vertex(ct, nx, ny, nz);
            add_to_vertex(cs, nx, ny, nz);
            add_to_vertex(cf, nx, ny, nz);
            pending_q.push_back(r);
        end else if (kind == mvn_pkg::KIND_READ) begin
            r.rkind = mvn_pkg::RES_READ;
            nx = 0; ny = 0; nz = 0;
            if (ucount[idx] != 0)
                unit_normal(nsum[idx][0], nsum[idx][1], nsum[idx][2], nx, ny, nz);
            r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
            r.sx = vpos[idx][0]; r.sy = vpos[idx][1]; r.sz = vpos[idx][2];
            r.uses = 8'(ucount[idx]);
            pending_q.push_back(r);
        end
    endfunction

    task automatic send_word(logic [1:0] kind, logic [10:0] idx, logic [15:0] px, py, pz,
                             logic [10:0] cf, cs, ct);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, ct, cs, cf, pz, py, px, idx};
        do @(posedge aclk); while (!s_tready);
        predict_word(kind, idx, px, py, pz, cf, cs, ct);
        words_sent++;
    endtask

    task automatic load_vertex(int idx, logic [15:0] px, py, pz);
        send_word(mvn_pkg::KIND_LOAD, 11'(idx), px, py, pz,
                  11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    task automatic send_triangle(int c, int b, int a);
        send_word(mvn_pkg::KIND_TRI, 11'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 11'(c), 11'(b), 11'(a));
    endtask

    task automatic read_vertex(int idx);
        send_word(mvn_pkg::KIND_READ, 11'(idx), 16'($urandom), 16'($urandom),
                  16'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    task automatic send_unused_kind();
        send_word(KIND_UNUSED, 11'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        normal_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = pending_q.pop_front();
                check_field("result_kind", e.rkind, m_tuser[0]);
                check_field("tri_out_first", e.tri_a, m_tdata[10:0]);
                check_field("tri_out_second", e.tri_b, m_tdata[21:11]);
                check_field("tri_out_third", e.tri_c, m_tdata[32:22]);
                check_field("normal_x", $signed(e.nx), $signed(m_tdata[48:33]));
                check_field("normal_y", $signed(e.ny), $signed(m_tdata[64:49]));
                check_field("normal_z", $signed(e.nz), $signed(m_tdata[80:65]));
                check_field("stored_x", $signed(e.sx), $signed(m_tdata[96:81]));
                check_field("stored_y", $signed(e.sy), $signed(m_tdata[112:97]));
                check_field("stored_z", $signed(e.sz), $signed(m_tdata[128:113]));
                check_field("use_total", e.uses, m_tdata[136:129]);
            end
        end
    end

    // extremes, stored-x clamp, degenerate and repeated-corner triangles, unused reads
    task automatic test_directed();
        load_vertex(0, 16'h8000, 16'h7FFF, 16'h8000);
        load_vertex(2047, 16'h7FFF, 16'h8000, 16'h7FFF);
        load_vertex(1, 16'h0000, 16'h0000, 16'h0000);
        load_vertex(2, 16'h1000, 16'h0000, 16'h0000);
        load_vertex(3, 16'h0000, 16'h1000, 16'h0000);
        load_vertex(4, 16'h2000, 16'h0000, 16'h0000);
        read_vertex(1);
        send_triangle(1, 2, 3);
        send_triangle(3, 2, 1);
        send_triangle(1, 1, 2);
        send_triangle(1, 2, 4);
        send_triangle(0, 2047, 1);
        send_unused_kind();
        read_vertex(1);
        read_vertex(2);
        read_vertex(4);
        read_vertex(0);
        read_vertex(2047);
        load_vertex(1, 16'h0000, 16'h0000, 16'h0000);
        read_vertex(1);
        send_triangle(2047, 0, 0);
        read_vertex(2047);
    endtask

    // one fan repeated until counts and sums saturate
    task automatic test_saturation();
        load_vertex(10, 16'h0000, 16'h0000, 16'h0100);
        load_vertex(11, 16'hF000, 16'h0000, 16'h0100);
        load_vertex(12, 16'h0000, 16'h1000, 16'h0100);
        for (int i = 0; i < 600; i++) begin
            send_triangle(12, 10, 11);
            if (i % 150 == 0) read_vertex(10);
        end
        read_vertex(10);
        read_vertex(11);
        read_vertex(12);
    endtask

    task automatic test_random_mesh(int n_words, int idle, int stall);
        int r, a, b, c;
        src_idle_pct = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < n_words; i++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                load_vertex(r < 6 ? $urandom_range(63) : $urandom_range(DEPTH - 1),
                            16'($urandom), 16'($urandom), 16'($urandom));
            end else if (r < 14) begin
                send_unused_kind();
            end else if (r < 72) begin
                a = loaded_q[$urandom_range(loaded_q.size() - 1)];
                b = loaded_q[$urandom_range(loaded_q.size() - 1)];
                c = ($urandom_range(9) == 0) ? a : loaded_q[$urandom_range(loaded_q.size() - 1)];
                send_triangle(c, b, a);
            end else begin
                read_vertex(loaded_q[$urandom_range(loaded_q.size() - 1)]);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_saturation();
        test_random_mesh(230, 0, 0);
        test_random_mesh(230, 68, 0);
        // hold off the source until the output side has fully drained
        wait_results_done();
        test_random_mesh(230, 0, 68);
        test_random_mesh(230, 27, 27);
        wait_results_done();
        repeat (300) @(posedge aclk);
        $display("Covered %0d input words and %0d result words: loads, triangles, reads,",
                 words_sent, results_seen);
        $display("saturating fans and unknown kinds under source gaps and sink stalls.");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
